// File: rtl/radix_digit_converter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix digit converter
// Shared implication forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_UNIT_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define RDC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdc checker: property violated");

// Next-cycle implication, disabled while reset is active.
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdc checker: property violated");

`endif

// File: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Widths, limits, defaults and sequencer states of the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

	localparam int VALUE_W         = 31;
	localparam int DIGIT_W         = 8;
	localparam int RADIX_W         = 9;
	localparam int RESULT_LIMIT    = 31;
	localparam int VALUE_BITS_DEF  = 31;
	localparam int DIGIT_SLOTS_DEF = 32;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_SEND = 4'b1000
	} rdc_state_t;

endpackage

`default_nettype wire

// File: rtl/rdc_if.sv
// ----------------------------------------------------------------------------
// rdc channel interfaces
// Valid/ready channels for input values and output digits.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdc_in_if import rdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic               last_digit;
	logic               empty_value;

	modport source (output valid, output digit, output last_digit, output empty_value,
		input ready);
	modport sink   (input valid, input digit, input last_digit, input empty_value,
		output ready);
endinterface

`default_nettype wire

// File: rtl/radix_digit_converter_unit.sv
// A zero value gives its single result in the cycle after it is taken.
// A nonzero value is divided once per digit. Each digit is then read from the
// store in ST_RD and offered in ST_SEND, the next one after the previous beat leaves.
// One value is in work at a time; the restoring divider yields one bit a cycle.
// Reset (arst_n low) sets radix to 10 and returns the sequencer to idle.
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// Converts an unsigned value into digits of a configured radix by repeated
// division in a shared divider and emits them most significant first.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_unit import rdc_pkg::*; #(
	parameter int VALUE_BITS  = VALUE_BITS_DEF,
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [RADIX_W-1:0] cfg_wdata,
	rdc_in_if.sink                  in_ch,
	rdc_out_if.source               out_ch
);

	// The store keeps at most this many digits; more significant ones are
	// dropped once it fills, which leaves the value modulo radix^LIMIT.
	localparam int LIMIT = (DIGIT_SLOTS < RESULT_LIMIT) ? DIGIT_SLOTS : RESULT_LIMIT;
	localparam int AW    = $clog2(LIMIT);
	localparam int CNT_W = $clog2(LIMIT + 1);

	rdc_state_t            state_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [CNT_W-1:0]      count_q;
	logic [AW-1:0]         k_q;
	logic                  empty_q;

	logic [VALUE_BITS-1:0] val_ext;
	logic [RADIX_W-1:0]    eff_radix;
	logic                  in_beat;
	logic                  out_beat;
	logic                  val_zero;

	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [DIGIT_W-1:0]    div_rem;
	logic                  div_finish;

	logic                  wr_en;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [CNT_W-1:0]      rd_idx;
	logic [DIGIT_W-1:0]    rd_data;
	logic                  is_last;

	// Bring the 31-bit input field to the divider width: only the low
	// VALUE_BITS bits take part, and a wider divider sees zeros on top.
	generate
		if (VALUE_BITS > VALUE_W) begin : g_widen
			assign val_ext = {{(VALUE_BITS - VALUE_W){1'b0}}, in_ch.value};
		end else if (VALUE_BITS == VALUE_W) begin : g_same
			assign val_ext = in_ch.value;
		end else begin : g_narrow
			assign val_ext = in_ch.value[VALUE_BITS-1:0];
		end
	endgenerate

	// Radix register; it must be written only while no value is in work, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	// A radix of 0 or 1 divides as 2 so the loop always ends, and anything
	// above 256 divides as 256 so every digit fits in eight bits.
	always_comb begin
		if (radix_q < RADIX_MIN) begin
			eff_radix = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			eff_radix = RADIX_MAX;
		end else begin
			eff_radix = radix_q;
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_beat     = in_ch.valid && in_ch.ready;
	assign out_beat    = out_ch.valid && out_ch.ready;
	assign val_zero    = (val_ext == '0);

	// Division ends once the quotient reaches zero or the store is full.
	assign div_finish   = (div_quot == '0) || ((count_q + CNT_W'(1)) == CNT_W'(LIMIT));
	assign div_start    = ((state_q == ST_IDLE) && in_beat && !val_zero) ||
		((state_q == ST_DIV) && div_done && !div_finish);
	assign div_dividend = (state_q == ST_IDLE) ? val_ext : div_quot;

	rdc_divider #(
		.VALUE_BITS (VALUE_BITS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (eff_radix),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// Remainders land least significant first at ascending addresses; they
	// are read back from the top of the fill down to address zero.
	assign wr_en   = (state_q == ST_DIV) && div_done;
	assign rd_en   = (state_q == ST_RD);
	assign rd_idx  = count_q - CNT_W'(1) - CNT_W'(k_q);
	assign rd_addr = rd_idx[AW-1:0];
	assign is_last = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);

	rdc_digit_store #(
		.DEPTH (LIMIT),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (div_rem),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer: take a value, divide until done, then read out and send one
	// digit per beat. A zero value goes straight to sending its empty beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
			empty_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						count_q <= '0;
						k_q     <= '0;
						if (val_zero) begin
							empty_q <= 1'b1;
							state_q <= ST_SEND;
						end else begin
							empty_q <= 1'b0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						count_q <= count_q + CNT_W'(1);
						if (div_finish) begin
							k_q     <= '0;
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_beat) begin
						if (empty_q || is_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The read register holds the digit for as long as the beat waits.
	assign out_ch.valid       = (state_q == ST_SEND);
	assign out_ch.digit       = empty_q ? '0 : rd_data;
	assign out_ch.last_digit  = empty_q || is_last;
	assign out_ch.empty_value = empty_q;

endmodule

`default_nettype wire

// File: rtl/rdc_divider.sv
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring divider, one quotient bit per cycle, for a radix of 2 to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_divider import rdc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [RADIX_W-1:0]    divisor,
	output logic                       done,
	output logic [VALUE_BITS-1:0]      quotient,
	output logic [DIGIT_W-1:0]         remainder
);

	localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] num_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    div_q;

	logic [RADIX_W-1:0]    trial;
	logic                  ge;
	logic [RADIX_W-1:0]    diff;

	// The partial remainder stays below the divisor, so it fits in eight bits.
	assign trial = {rem_q, num_q[VALUE_BITS-1]};
	assign ge    = (trial >= div_q);
	assign diff  = trial - div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(VALUE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// File: rtl/rdc_digit_store.sv
// ----------------------------------------------------------------------------
// rdc_digit_store
// Digit memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_digit_store import rdc_pkg::*; #(
	parameter int DEPTH = RESULT_LIMIT,
	parameter int AW    = $clog2(RESULT_LIMIT)
) (
	input  wire logic               clk,
	input  wire logic               wr_en,
	input  wire logic [AW-1:0]      wr_addr,
	input  wire logic [DIGIT_W-1:0] wr_data,
	input  wire logic               rd_en,
	input  wire logic [AW-1:0]      rd_addr,
	output logic [DIGIT_W-1:0]      rd_data
);

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks on the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_digit_converter_unit_assert.svh"

module rdc_checker import rdc_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [DIGIT_W-1:0] digit,
	input wire logic               last_digit,
	input wire logic               empty_value
);

	// An empty beat is a complete group of its own with a zero digit.
	`RDC_ASSERT_IMP(a_empty_framed, out_valid && empty_value, last_digit && (digit == '0))

	// The block works on one value at a time: no new value while a beat is shown.
	`RDC_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)

	// After the final beat of a group the block is ready for the next value.
	`RDC_ASSERT_NEXT(a_last_frees, out_valid && out_ready && last_digit, in_ready)

	// A taken value closes the input until its digits are all sent.
	`RDC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

	// A stalled beat holds its digit.
	`RDC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(digit))

endmodule

bind radix_digit_converter_unit rdc_checker u_rdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.digit       (out_ch.digit),
	.last_digit  (out_ch.last_digit),
	.empty_value (out_ch.empty_value)
);

`default_nettype wire

// File: test/radix_digit_converter_unit_tb.sv
// ----------------------------------------------------------------------------
// radix_digit_converter_unit_tb
// Self-checking bench for the radix digit converter. A short table of
// directed values and radix settings runs first. Phases of random values
// follow, each under its own radix. A local predictor expands every accepted
// value into its expected digit beats, and each output beat is compared with
// the oldest expected beat.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_unit_tb;

	import rdc_pkg::*;

	// One expected or observed output beat.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last_digit;
		logic               empty_value;
	} digit_beat_t;

	// One row of the directed table. A row with a nonzero n_typed carries its
	// expected digits in its low n_typed bytes, most significant highest. Every
	// other row is checked against the predictor.
	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic [VALUE_W-1:0] value;
		logic [2:0]         n_typed;
		logic [31:0]        typed_digits;
		logic               typed_empty;
	} stim_row_t;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
	localparam int DIGIT_CAP      = (DIGIT_SLOTS_DEF < RESULT_LIMIT) ?
		DIGIT_SLOTS_DEF : RESULT_LIMIT;
	localparam int N_PHASES       = 10;
	localparam int PHASE_ITEMS    = 42;
	localparam int SQUEEZE_AT     = 400;
	localparam int SQUEEZE_CYCLES = 3000;
	localparam int SETTLE_CYCLES  = 1200;
	localparam int N_ROWS         = 20;

	// The directed table: reset radix, both radix extremes, the settings that
	// fall below and above the legal radix range, zero inputs and the
	// largest value.
	localparam stim_row_t DIRECTED [N_ROWS] = '{
		'{9'd10,  31'd0,          3'd1, 32'h00000000, 1'b1},
		'{9'd10,  31'd7,          3'd1, 32'h00000007, 1'b0},
		'{9'd10,  31'd10,         3'd2, 32'h00000100, 1'b0},
		'{9'd10,  31'h7FFFFFFF,   3'd0, 32'h00000000, 1'b0},
		'{9'd2,   31'd1,          3'd1, 32'h00000001, 1'b0},
		'{9'd2,   31'h7FFFFFFF,   3'd0, 32'h00000000, 1'b0},
		'{9'd2,   31'h40000000,   3'd0, 32'h00000000, 1'b0},
		'{9'd0,   31'd5,          3'd0, 32'h00000000, 1'b0},
		'{9'd1,   31'd6,          3'd0, 32'h00000000, 1'b0},
		'{9'd1,   31'd0,          3'd1, 32'h00000000, 1'b1},
		'{9'd3,   31'h7FFFFFFF,   3'd0, 32'h00000000, 1'b0},
		'{9'd255, 31'h7FFFFFFF,   3'd0, 32'h00000000, 1'b0},
		'{9'd256, 31'h7FFFFFFF,   3'd4, 32'h7FFFFFFF, 1'b0},
		'{9'd256, 31'd255,        3'd1, 32'h000000FF, 1'b0},
		'{9'd256, 31'd256,        3'd2, 32'h00000100, 1'b0},
		'{9'd257, 31'h12345678,   3'd4, 32'h12345678, 1'b0},
		'{9'd511, 31'd0,          3'd1, 32'h00000000, 1'b1},
		'{9'd511, 31'h55AA55AA,   3'd4, 32'h55AA55AA, 1'b0},
		'{9'd16,  31'h2AAAAAAA,   3'd0, 32'h00000000, 1'b0},
		'{9'd36,  31'd35,         3'd1, 32'h00000023, 1'b0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [RADIX_W-1:0] cfg_wdata = '0;

	rdc_in_if  in_ch ();
	rdc_out_if out_ch ();

	radix_digit_converter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Period of 4 time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expected digit beats, oldest first, and the radix the block holds now.
	digit_beat_t        expected_digits [$];
	logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
	int                 mismatches = 0;
	// In the final phase neither side idles.
	bit                 calm = 1'b0;
	bit                 sender_steady = 1'b0;

	// The block maps a radix below the legal range to the minimum and one
	// above it to the maximum, so that division always ends and digits fit.
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) begin
			return RADIX_MIN;
		end
		if (r > RADIX_MAX) begin
			return RADIX_MAX;
		end
		return r;
	endfunction

	// Expands one value into its digit beats under radix r and queues them.
	// Remainders come out least significant first and are sent in reverse.
	// A zero value yields a single beat flagged empty.
	function automatic void expand_digits(input logic [VALUE_W-1:0] v,
		input logic [RADIX_W-1:0] r);
		logic [VALUE_W-1:0] rest;
		logic [RADIX_W-1:0] base;
		logic [DIGIT_W-1:0] rems [DIGIT_CAP];
		int                 n;
		digit_beat_t        b;
		base = clamp_radix(r);
		rest = v;
		n = 0;
		if (v == '0) begin
			b = '{digit: '0, last_digit: 1'b1, empty_value: 1'b1};
			expected_digits.push_back(b);
			return;
		end
		while (rest != '0 && n < DIGIT_CAP) begin
			rems[n] = DIGIT_W'(rest % base);
			rest = rest / base;
			n++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			b = '{digit: rems[k], last_digit: (k == 0), empty_value: 1'b0};
			expected_digits.push_back(b);
		end
	endfunction

	// Random value with a bias toward digit-count boundaries of radix r:
	// zero, the largest value, small values, exact powers and one below.
	function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
		longint unsigned    pw;
		int                 k;
		logic [RADIX_W-1:0] base;
		base = clamp_radix(r);
		case ($urandom_range(0, 9))
			0: begin
				return '0;
			end
			1: begin
				return VALUE_MAX;
			end
			2: begin
				return VALUE_W'($urandom_range(1, 2 * base));
			end
			3: begin
				pw = 1;
				k = $urandom_range(1, VALUE_W);
				while (k > 0 && pw * base <= longint'(VALUE_MAX)) begin
					pw = pw * base;
					k--;
				end
				return VALUE_W'(pw - $urandom_range(0, 1));
			end
			4, 5, 6: begin
				return VALUE_W'($urandom());
			end
			default: begin
				return VALUE_W'($urandom()) >> $urandom_range(1, VALUE_W - 1);
			end
		endcase
	endfunction

	// Offers one value and returns at the edge that accepts it. Valid is not
	// dropped between back-to-back beats.
	task automatic offer_value(input logic [VALUE_W-1:0] v);
		if (!calm && !sender_steady && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		do begin
			@(posedge clk);
		end while (!in_ch.ready);
	endtask

	// Lets the block run dry: no value on offer and every expected beat seen.
	// All values give at least one beat, so the block is idle once the last
	// one has left.
	task automatic quiesce();
		in_ch.valid <= 1'b0;
		while (expected_digits.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radix_shadow = r;
	endtask

	// Output side: checks every beat against the oldest expectation and
	// drives ready. Stalls come in short random bursts while the side is in a
	// lazy spell. Once, after SQUEEZE_AT beats, ready stays low for a long
	// stretch so that the block holds a waiting beat and stalls its input.
	int  beats_taken = 0;
	int  hold_left = 0;
	int  sink_cycles = 0;
	bit  sink_lazy = 1'b1;

	always @(posedge clk) begin
		digit_beat_t got;
		digit_beat_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.digit, out_ch.last_digit, out_ch.empty_value};
			if (expected_digits.size() == 0) begin
				$error("unexpected beat: digit %0d last_digit %0b empty_value %0b",
					got.digit, got.last_digit, got.empty_value);
				mismatches++;
			end else begin
				want = expected_digits.pop_front();
				if (got.digit !== want.digit) begin
					$error("digit: expected %0d, actual %0d", want.digit, got.digit);
					mismatches++;
				end
				if (got.last_digit !== want.last_digit) begin
					$error("last_digit: expected %0b, actual %0b",
						want.last_digit, got.last_digit);
					mismatches++;
				end
				if (got.empty_value !== want.empty_value) begin
					$error("empty_value: expected %0b, actual %0b",
						want.empty_value, got.empty_value);
					mismatches++;
				end
			end
			beats_taken++;
			if (beats_taken == SQUEEZE_AT) begin
				hold_left = SQUEEZE_CYCLES;
			end
		end
		if (sink_cycles % 128 == 0) begin
			sink_lazy = $urandom_range(0, 1);
		end
		sink_cycles++;
		if (hold_left == 0 && !calm && sink_lazy && $urandom_range(0, 3) == 0) begin
			hold_left = $urandom_range(1, 16);
		end
		if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Stimulus and end of run.
	initial begin
		stim_row_t          row;
		digit_beat_t        b;
		logic [VALUE_W-1:0] v;
		logic [RADIX_W-1:0] r;
		in_ch.valid <= 1'b0;
		in_ch.value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. A radix change waits until the block is idle.
		for (int i = 0; i < N_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.radix != radix_shadow) begin
				quiesce();
				write_radix(row.radix);
			end
			offer_value(row.value);
			if (row.n_typed == 0) begin
				expand_digits(row.value, radix_shadow);
			end else begin
				for (int k = 0; k < row.n_typed; k++) begin
					b.digit       = row.typed_digits[8 * (row.n_typed - 1 - k) +: 8];
					b.last_digit  = (k == row.n_typed - 1);
					b.empty_value = row.typed_empty;
					expected_digits.push_back(b);
				end
			end
		end

		// Random phases. The first ones visit the radix extremes and the
		// out-of-range settings; the last one runs with no idling at all.
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0:       r = RADIX_MIN;
				1:       r = RADIX_MAX;
				2:       r = '1;
				3:       r = '0;
				4:       r = 9'd1;
				5:       r = RADIX_MAX + 9'd1;
				default: r = RADIX_W'($urandom_range(0, (1 << RADIX_W) - 1));
			endcase
			quiesce();
			write_radix(r);
			calm = (phase == N_PHASES - 1);
			sender_steady = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				v = pick_value(radix_shadow);
				offer_value(v);
				expand_digits(v, radix_shadow);
			end
		end

		quiesce();
		// Any stray beat would show up well within one full conversion.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_digits.size() == 0) begin
			$display("radix_digit_converter_unit regression: pass");
		end else begin
			$display("radix_digit_converter_unit regression: fail");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#20_000_000;
		$display("radix_digit_converter_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire

// File: radix_digit_converter_unit.f
+incdir+rtl
rtl/rdc_pkg.sv
rtl/rdc_if.sv
rtl/rdc_divider.sv
rtl/rdc_digit_store.sv
rtl/radix_digit_converter_unit.sv
rtl/rdc_checker.sv
test/radix_digit_converter_unit_tb.sv
